// File: rtl/core/height_to_color_ramp_assert.svh
// ----------------------------------------------------------------------------
// height_to_color_ramp_assert.svh
// Assertion macros shared by the height-to-color ramp RTL.
// ----------------------------------------------------------------------------
`ifndef HEIGHT_TO_COLOR_RAMP_ASSERT_SVH
`define HEIGHT_TO_COLOR_RAMP_ASSERT_SVH

`ifndef SYNTHESIS

// expr holds at every edge out of reset
`define HCR_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("hcr assertion failed");

// cond implies expr at the same edge
`define HCR_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("hcr assertion failed");

`else

`define HCR_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define HCR_ASSERT_IMPLIES(label, clk, rst_n, cond, expr)

`endif

`endif

// File: rtl/core/hcr_pkg.sv
// ----------------------------------------------------------------------------
// hcr_pkg
// Types, ramp tables and biome thresholds for the height-to-color ramp.
// ----------------------------------------------------------------------------
package hcr_pkg;

    localparam int HEIGHT_W  = 16;
    localparam int H100_W    = 23;
    localparam int FRAC_BITS = 15;
    localparam int PCT_W     = 7;
    localparam int WIDTH_W   = 5;
    localparam int N_W       = 20;
    localparam int LEVEL_W   = 8;
    localparam int CLASS_W   = 3;
    localparam int RECIP_W   = 19;
    localparam int RECIP_SH  = 20;
    localparam int Q_W       = 13;

    localparam int SEG_COUNT   = 7;
    localparam int BIOME_EDGES = 6;

    typedef logic [2:0]         seg_idx_t;
    typedef logic [N_W-1:0]     frac_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [CLASS_W-1:0] class_t;

    typedef enum logic [CLASS_W-1:0] {
        CLS_DEEP      = 3'd0,
        CLS_SHALLOW   = 3'd1,
        CLS_SAND      = 3'd2,
        CLS_LOWLAND   = 3'd3,
        CLS_WOODLAND  = 3'd4,
        CLS_HIGHLAND  = 3'd5,
        CLS_SUMMIT    = 3'd6
    } biome_t;

    typedef struct packed {
        level_t red;
        level_t green;
        level_t blue;
    } rgb_t;

    typedef struct packed {
        seg_idx_t seg;
        frac_t    n;
        class_t   cls;
    } seg_info_t;

    function automatic logic [PCT_W-1:0] seg_start_pct(input seg_idx_t seg);
        logic [PCT_W-1:0] r;
        case (seg)
            3'd0:    r = 7'd0;
            3'd1:    r = 7'd30;
            3'd2:    r = 7'd38;
            3'd3:    r = 7'd42;
            3'd4:    r = 7'd50;
            3'd5:    r = 7'd65;
            3'd6:    r = 7'd80;
            default: r = 7'd80;
        endcase
        return r;
    endfunction

    function automatic logic [WIDTH_W-1:0] seg_width_pct(input seg_idx_t seg);
        logic [WIDTH_W-1:0] r;
        case (seg)
            3'd0:    r = 5'd30;
            3'd1:    r = 5'd8;
            3'd2:    r = 5'd4;
            3'd3:    r = 5'd8;
            3'd4:    r = 5'd15;
            3'd5:    r = 5'd15;
            3'd6:    r = 5'd20;
            default: r = 5'd20;
        endcase
        return r;
    endfunction

    // ceil(2^20 / width), exact for quotients below 2^13
    function automatic logic [RECIP_W-1:0] seg_recip(input seg_idx_t seg);
        logic [RECIP_W-1:0] r;
        case (seg)
            3'd0:    r = 19'd34953;
            3'd1:    r = 19'd131072;
            3'd2:    r = 19'd262144;
            3'd3:    r = 19'd131072;
            3'd4:    r = 19'd69906;
            3'd5:    r = 19'd69906;
            3'd6:    r = 19'd52429;
            default: r = 19'd52429;
        endcase
        return r;
    endfunction

    function automatic rgb_t ramp_lo(input seg_idx_t seg);
        rgb_t r;
        case (seg)
            3'd0:    r = '{8'd8,   8'd24,  8'd58};
            3'd1:    r = '{8'd15,  8'd40,  8'd90};
            3'd2:    r = '{8'd40,  8'd85,  8'd150};
            3'd3:    r = '{8'd210, 8'd190, 8'd140};
            3'd4:    r = '{8'd140, 8'd160, 8'd90};
            3'd5:    r = '{8'd80,  8'd120, 8'd60};
            3'd6:    r = '{8'd70,  8'd60,  8'd55};
            default: r = '{8'd70,  8'd60,  8'd55};
        endcase
        return r;
    endfunction

    function automatic rgb_t ramp_hi(input seg_idx_t seg);
        rgb_t r;
        case (seg)
            3'd0:    r = '{8'd15,  8'd40,  8'd90};
            3'd1:    r = '{8'd40,  8'd85,  8'd150};
            3'd2:    r = '{8'd210, 8'd190, 8'd140};
            3'd3:    r = '{8'd140, 8'd160, 8'd90};
            3'd4:    r = '{8'd80,  8'd120, 8'd60};
            3'd5:    r = '{8'd70,  8'd60,  8'd55};
            3'd6:    r = '{8'd90,  8'd80,  8'd75};
            default: r = '{8'd90,  8'd80,  8'd75};
        endcase
        return r;
    endfunction

    function automatic logic [PCT_W-1:0] biome_edge_pct(input logic [2:0] idx);
        logic [PCT_W-1:0] r;
        case (idx)
            3'd0:    r = 7'd30;
            3'd1:    r = 7'd38;
            3'd2:    r = 7'd42;
            3'd3:    r = 7'd50;
            3'd4:    r = 7'd70;
            3'd5:    r = 7'd85;
            default: r = 7'd85;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/hcr_seg_select.sv
// ----------------------------------------------------------------------------
// hcr_seg_select
// Scales the height by 100, picks the ramp segment and biome class, and
// forms the clamped offset into the segment.
// ----------------------------------------------------------------------------
module hcr_seg_select (
    input  logic [hcr_pkg::HEIGHT_W-1:0] height_sample,
    output hcr_pkg::seg_info_t           info
);
    import hcr_pkg::*;

    logic [H100_W-1:0]    h100;
    logic [H100_W-1:0]    n_full;
    logic [N_W-1:0]       d_full;
    seg_idx_t             seg;
    class_t               cls;

    always_comb
    begin
        h100 = H100_W'(height_sample) * H100_W'(100);

        seg = 3'd0;
        for (int i = 1; i < SEG_COUNT; i++)
        begin
            if (h100 >= {1'b0, seg_start_pct(3'(i)), 15'b0})
            begin
                seg = 3'(i);
            end
        end

        cls = CLS_DEEP;
        for (int i = 0; i < BIOME_EDGES; i++)
        begin
            if (h100 >= {1'b0, biome_edge_pct(3'(i)), 15'b0})
            begin
                cls = 3'(i + 1);
            end
        end

        n_full = h100 - {1'b0, seg_start_pct(seg), 15'b0};
        d_full = {seg_width_pct(seg), 15'b0};

        info.seg = seg;
        info.cls = cls;
        // clamp t to 1
        if (n_full > H100_W'(d_full))
        begin
            info.n = d_full;
        end
        else
        begin
            info.n = n_full[N_W-1:0];
        end
    end

endmodule

// File: rtl/core/hcr_channel.sv
// ----------------------------------------------------------------------------
// hcr_channel
// Two-stage blend of one color channel: scaled interpolation numerator,
// then division by the segment width through a reciprocal multiply.
// ----------------------------------------------------------------------------
module hcr_channel (
    input  logic              clk,
    input  hcr_pkg::seg_idx_t seg,
    input  hcr_pkg::frac_t    n,
    input  hcr_pkg::level_t   lo,
    input  hcr_pkg::level_t   hi,
    output hcr_pkg::level_t   level
);
    import hcr_pkg::*;

    logic [13:0]            wa;
    logic [28:0]            base;
    logic signed [8:0]      delta;
    logic signed [29:0]     prod;
    logic signed [31:0]     x;
    logic [Q_W-1:0]         q_next;
    logic [Q_W-1:0]         q_reg;
    seg_idx_t               seg_reg;
    logic [Q_W+RECIP_W-1:0] div_prod;
    level_t                 level_next;
    level_t                 level_reg;

    always_comb
    begin
        wa    = 14'(seg_width_pct(seg)) * 14'({lo, 1'b1});
        base  = {wa, 15'b0};
        delta = signed'({1'b0, hi}) - signed'({1'b0, lo});
        prod  = 30'(delta) * 30'(signed'({1'b0, n}));
        x     = signed'({3'b000, base}) + (32'(prod) <<< 1);
        q_next = x[28:16];
    end

    always_comb
    begin
        div_prod   = (Q_W+RECIP_W)'(q_reg) * (Q_W+RECIP_W)'(seg_recip(seg_reg));
        level_next = div_prod[RECIP_SH+LEVEL_W-1:RECIP_SH];
    end

    always_ff @(posedge clk)
    begin
        q_reg     <= q_next;
        seg_reg   <= seg;
        level_reg <= level_next;
    end

    assign level = level_reg;

endmodule

// File: rtl/core/height_to_color_ramp.sv
// ----------------------------------------------------------------------------
// height_to_color_ramp
// Maps one Q1.15 height sample to a piecewise-linear ramp color and a
// biome class.
//
// Usage:
//   Drive height_sample and raise start; the item is taken at any rising
//   edge with start high and busy low. busy stays low, so one item can be
//   taken every cycle.
//   The result (red_level, green_level, blue_level, biome_class) shows for
//   one cycle with done high, once the item has passed the register stages
//   listed below; items come out in order.
//   Latency is four register stages: input register, segment select,
//   blend numerator (channel multiply), width division (reciprocal
//   multiply). Throughput is one item per cycle.
//   The receiver has no stall; it must take each result as done pulses.
//   Reset clears all valid bits; items in flight are dropped and no done
//   pulse follows.
// ----------------------------------------------------------------------------
`include "height_to_color_ramp_assert.svh"

module height_to_color_ramp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [hcr_pkg::HEIGHT_W-1:0] height_sample,
    output logic                         done,
    output logic [hcr_pkg::LEVEL_W-1:0]  red_level,
    output logic [hcr_pkg::LEVEL_W-1:0]  green_level,
    output logic [hcr_pkg::LEVEL_W-1:0]  blue_level,
    output logic [hcr_pkg::CLASS_W-1:0]  biome_class
);
    import hcr_pkg::*;

    logic                v0_reg, v1_reg, v2_reg, v3_reg;
    logic                accept;
    logic [HEIGHT_W-1:0] h_reg;
    seg_info_t           info_next;
    seg_info_t           info_reg;
    class_t              cls2_reg, cls3_reg;
    rgb_t                lo_c, hi_c;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= accept;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg    <= height_sample;
        info_reg <= info_next;
        cls2_reg <= info_reg.cls;
        cls3_reg <= cls2_reg;
    end

    hcr_seg_select u_seg_select (
        .height_sample (h_reg),
        .info          (info_next)
    );

    assign lo_c = ramp_lo(info_reg.seg);
    assign hi_c = ramp_hi(info_reg.seg);

    hcr_channel u_red (
        .clk   (clk),
        .seg   (info_reg.seg),
        .n     (info_reg.n),
        .lo    (lo_c.red),
        .hi    (hi_c.red),
        .level (red_level)
    );

    hcr_channel u_green (
        .clk   (clk),
        .seg   (info_reg.seg),
        .n     (info_reg.n),
        .lo    (lo_c.green),
        .hi    (hi_c.green),
        .level (green_level)
    );

    hcr_channel u_blue (
        .clk   (clk),
        .seg   (info_reg.seg),
        .n     (info_reg.n),
        .lo    (lo_c.blue),
        .hi    (hi_c.blue),
        .level (blue_level)
    );

    assign done        = v3_reg;
    assign biome_class = cls3_reg;

    `HCR_ASSERT_ALWAYS(a_latency, clk, rst_n, !($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3)) || (done == $past(accept, 4)))
    `HCR_ASSERT_IMPLIES(a_class_range, clk, rst_n, done, biome_class <= CLS_SUMMIT)
    `HCR_ASSERT_IMPLIES(a_seg_class, clk, rst_n, v1_reg, (info_reg.seg > 3'd3) || (info_reg.cls == info_reg.seg))
    `HCR_ASSERT_IMPLIES(a_n_clamp, clk, rst_n, v1_reg, info_reg.n <= {seg_width_pct(info_reg.seg), 15'b0})

endmodule
